[rtl/sdeq_pkg.sv]
// Package for the searchable double-ended queue.
// Holds the ring depth, derived widths, operation and status codes, and the
// word and control struct types shared by the controller, datapath and top level.
package sdeq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int POS_W = 4;

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_LIST       = 3'd4;
    localparam logic [2:0] KIND_SEARCH     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic signed [KEY_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    do_push;
        logic    idx_clr;
        logic    idx_back;
        logic    idx_inc;
        logic    pop_front;
        logic    pop_back;
        logic    emit;
        t_status emit_status;
        logic    emit_data;
        logic    emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       full;
        logic       idx_last;
        logic       match;
    } t_dp_stat;

endpackage

[rtl/sdeq_ctrl.sv]
// Controller state machine of the searchable double-ended queue.
// Sequences each operation and drives the datapath through sdeq_pkg::t_dp_cmd.
// Depends on sdeq_pkg.
module sdeq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sdeq_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output sdeq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_POP    = 4'b0100,
        S_WALK   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.emit_status = sdeq_pkg::ST_OK;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.kind)
                    sdeq_pkg::KIND_PUSH_FRONT, sdeq_pkg::KIND_PUSH_BACK: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.emit_status = sdeq_pkg::ST_FULL;
                        end else begin
                            o_cmd.do_push = 1'b1;
                        end
                    end
                    sdeq_pkg::KIND_POP_FRONT, sdeq_pkg::KIND_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            o_cmd.emit_status = sdeq_pkg::ST_EMPTY;
                        end else begin
                            // The index doubles as the read pointer and the position.
                            o_cmd.idx_clr = (i_stat.kind == sdeq_pkg::KIND_POP_FRONT);
                            o_cmd.idx_back = (i_stat.kind == sdeq_pkg::KIND_POP_BACK);
                            n_state = S_POP;
                        end
                    end
                    sdeq_pkg::KIND_LIST, sdeq_pkg::KIND_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            o_cmd.emit_status = sdeq_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_POP: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_data = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.pop_front = (i_stat.kind == sdeq_pkg::KIND_POP_FRONT);
                o_cmd.pop_back = (i_stat.kind != sdeq_pkg::KIND_POP_FRONT);
                n_state = S_IDLE;
            end
            S_WALK: begin
                if (i_stat.kind == sdeq_pkg::KIND_LIST) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_data = 1'b1;
                    o_cmd.emit_last = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else if (i_stat.match) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_data = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.idx_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_status = sdeq_pkg::ST_NOTFOUND;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // An accepted word always makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after an accepted word");

    // The final result of a word returns the controller to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("controller not idle after final result");
`endif

endmodule

[rtl/sdeq_datapath.sv]
// Datapath of the searchable double-ended queue: key ring memory, front
// pointer, entry count, walk index and the registered result word.
// Depends on sdeq_pkg.
module sdeq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdeq_pkg::t_in_item  i_item,
    input  sdeq_pkg::t_dp_cmd   i_cmd,
    output sdeq_pkg::t_dp_stat  o_stat,
    output logic                o_strobe,
    output sdeq_pkg::t_out_item o_result
);

    localparam int IW = sdeq_pkg::IDX_W;
    localparam int CW = sdeq_pkg::CNT_W;

    logic signed [sdeq_pkg::KEY_W-1:0] mem [sdeq_pkg::DEPTH];

    sdeq_pkg::t_in_item  r_item;
    logic [IW-1:0]       r_front;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_idx;
    logic signed [sdeq_pkg::KEY_W-1:0] r_rdata;
    logic                r_strobe;
    sdeq_pkg::t_out_item r_out;

    logic [IW-1:0]       n_idx;
    logic [CW-1:0]       count_m1;
    logic [IW-1:0]       rd_slot;
    logic [IW-1:0]       wr_slot;
    logic [IW-1:0]       front_dec;
    logic [IW-1:0]       front_inc;
    logic [IW+sdeq_pkg::POS_W-1:0] idx_ext;
    logic                full;
    logic                empty;

    // Ring slot of the entry at a given offset from the front.
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [IW-1:0] offs);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, offs};
        if (s >= (IW + 1)'(sdeq_pkg::DEPTH)) begin
            s = s - (IW + 1)'(sdeq_pkg::DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign full = (r_count == CW'(sdeq_pkg::DEPTH));
    assign empty = (r_count == '0);
    assign count_m1 = r_count - CW'(1);
    assign front_dec = (r_front == '0) ? IW'(sdeq_pkg::DEPTH - 1) : r_front - IW'(1);
    assign front_inc = (r_front == IW'(sdeq_pkg::DEPTH - 1)) ? '0 : r_front + IW'(1);

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_back) begin
            n_idx = count_m1[IW-1:0];
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IW'(1);
        end
    end

    assign rd_slot = slot_of(r_front, n_idx);
    assign wr_slot = (r_item.kind == sdeq_pkg::KIND_PUSH_FRONT) ? front_dec
                                                                : slot_of(r_front, r_count[IW-1:0]);
    assign idx_ext = {{sdeq_pkg::POS_W{1'b0}}, r_idx};

    assign o_stat.kind = r_item.kind;
    assign o_stat.empty = empty;
    assign o_stat.full = full;
    assign o_stat.idx_last = (CW'(r_idx) == count_m1);
    assign o_stat.match = (r_rdata == r_item.key);

    // The memory is read every cycle at the slot the next index points to.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_push) begin
            mem[wr_slot] <= r_item.key;
        end
        r_rdata <= mem[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.do_push) begin
                r_count <= r_count + CW'(1);
                if (r_item.kind == sdeq_pkg::KIND_PUSH_FRONT) begin
                    r_front <= front_dec;
                end
            end else if (i_cmd.pop_front) begin
                r_count <= count_m1;
                r_front <= front_inc;
            end else if (i_cmd.pop_back) begin
                r_count <= count_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.emit) begin
            r_out.status <= i_cmd.emit_status;
            r_out.value <= i_cmd.emit_data ? r_rdata : '0;
            r_out.position <= i_cmd.emit_data ? idx_ext[sdeq_pkg::POS_W-1:0] : '0;
            r_out.last <= i_cmd.emit_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(sdeq_pkg::DEPTH))
        else $error("entry count above ring depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_push |-> !full)
        else $error("push into a full ring");
`endif

endmodule

[rtl/searchable_double_ended_queue_top.sv]
// Top level of the searchable double-ended queue.
// Joins the controller (sdeq_ctrl) and the datapath (sdeq_datapath).
// Depends on sdeq_pkg.
//
// Usage: drive i_cmd and raise start; the word is taken at a rising edge
// where start is high and busy is low. busy stays high until the operation
// has issued its final result. Each result word appears on o_result for
// exactly one cycle with o_strobe high; o_result.last marks the final one.
// The receiver cannot stall the block, so it must take every strobed word.
// Sequencing: pushes and empty or full cases give one result from the decode
// state, and the block takes no new word until it is idle again. Pops give
// theirs from a further pop state, since the key ring memory has a registered
// read port. List and search walk the ring one entry per cycle through that
// same read port, up to DEPTH entries. Undefined kind codes give no result
// and free the block.
// Reset (i_rst_n low, synchronous) empties the queue and idles the
// controller; the key memory itself is not cleared.
module searchable_double_ended_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  sdeq_pkg::t_in_item  i_cmd,
    output logic                busy,
    output logic                o_strobe,
    output sdeq_pkg::t_out_item o_result
);

    sdeq_pkg::t_dp_cmd  dp_cmd;
    sdeq_pkg::t_dp_stat dp_stat;

    sdeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    sdeq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_cmd),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

[tb/sv/searchable_double_ended_queue_checker.sv]
`timescale 1ns / 100ps
// Checker for the searchable double-ended queue: it keeps its own copy of the key ring,
// predicts the result words of every accepted command word and compares them in order.
// Depends on sdeq_pkg.
module searchable_double_ended_queue_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  sdeq_pkg::t_in_item  i_cmd,
    input  logic                i_strobe,
    input  sdeq_pkg::t_out_item i_result,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic signed [sdeq_pkg::KEY_W-1:0] ring_keys [sdeq_pkg::DEPTH];
    int                      head_slot;
    int                      fill_count;
    int                      mismatch_total = 0;
    sdeq_pkg::t_out_item     awaited_results [$];

    function automatic sdeq_pkg::t_out_item single_word(
        input sdeq_pkg::t_status status,
        input logic signed [sdeq_pkg::KEY_W-1:0] value,
        input int position);
        sdeq_pkg::t_out_item w;
        w.status   = status;
        w.value    = value;
        w.position = sdeq_pkg::POS_W'(position);
        w.last     = 1'b1;
        return w;
    endfunction

    task automatic predict_operation(input sdeq_pkg::t_in_item cmd);
        sdeq_pkg::t_out_item w;
        int        slot;
        int        hit;
        case (cmd.kind)
            sdeq_pkg::KIND_PUSH_FRONT, sdeq_pkg::KIND_PUSH_BACK: begin
                if (fill_count >= sdeq_pkg::DEPTH) begin
                    awaited_results.push_back(single_word(sdeq_pkg::ST_FULL, '0, 0));
                end else begin
                    if (cmd.kind == sdeq_pkg::KIND_PUSH_FRONT) begin
                        head_slot = (head_slot + sdeq_pkg::DEPTH - 1) % sdeq_pkg::DEPTH;
                        ring_keys[head_slot] = cmd.key;
                    end else begin
                        ring_keys[(head_slot + fill_count) % sdeq_pkg::DEPTH] = cmd.key;
                    end
                    fill_count++;
                    awaited_results.push_back(single_word(sdeq_pkg::ST_OK, '0, 0));
                end
            end
            sdeq_pkg::KIND_POP_FRONT: begin
                if (fill_count == 0) begin
                    awaited_results.push_back(single_word(sdeq_pkg::ST_EMPTY, '0, 0));
                end else begin
                    awaited_results.push_back(
                        single_word(sdeq_pkg::ST_OK, ring_keys[head_slot], 0));
                    head_slot = (head_slot + 1) % sdeq_pkg::DEPTH;
                    fill_count--;
                end
            end
            sdeq_pkg::KIND_POP_BACK: begin
                if (fill_count == 0) begin
                    awaited_results.push_back(single_word(sdeq_pkg::ST_EMPTY, '0, 0));
                end else begin
                    fill_count--;
                    slot = (head_slot + fill_count) % sdeq_pkg::DEPTH;
                    awaited_results.push_back(
                        single_word(sdeq_pkg::ST_OK, ring_keys[slot], fill_count));
                end
            end
            sdeq_pkg::KIND_LIST: begin
                if (fill_count == 0) begin
                    awaited_results.push_back(single_word(sdeq_pkg::ST_EMPTY, '0, 0));
                end else begin
                    for (int i = 0; i < fill_count; i++) begin
                        w = single_word(sdeq_pkg::ST_OK,
                                        ring_keys[(head_slot + i) % sdeq_pkg::DEPTH], i);
                        w.last = (i + 1 == fill_count);
                        awaited_results.push_back(w);
                    end
                end
            end
            sdeq_pkg::KIND_SEARCH: begin
                if (fill_count == 0) begin
                    awaited_results.push_back(single_word(sdeq_pkg::ST_EMPTY, '0, 0));
                end else begin
                    hit = -1;
                    for (int i = 0; i < fill_count; i++) begin
                        if (hit < 0 &&
                            ring_keys[(head_slot + i) % sdeq_pkg::DEPTH] == cmd.key) begin
                            hit = i;
                        end
                    end
                    if (hit >= 0) begin
                        awaited_results.push_back(single_word(sdeq_pkg::ST_OK, cmd.key, hit));
                    end else begin
                        awaited_results.push_back(single_word(sdeq_pkg::ST_NOTFOUND, '0, 0));
                    end
                end
            end
            default: begin
                // The two unused codes leave the ring alone and give no word.
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            mismatch_total++;
        end
    endtask

    task automatic check_result(input sdeq_pkg::t_out_item got);
        sdeq_pkg::t_out_item want;
        if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d/%0d",
                     $realtime, got.status, got.value, got.position, got.last);
            mismatch_total++;
        end else begin
            want = awaited_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("value", want.value, got.value);
            compare_field("position", want.position, got.position);
            compare_field("last", want.last, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot  = 0;
            fill_count = 0;
            awaited_results.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                check_result(i_result);
            end
            if (i_start && !i_busy) begin
                predict_operation(i_cmd);
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= awaited_results.size();
    end

endmodule

[tb/sv/searchable_double_ended_queue_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the searchable double-ended queue: drives command words with random
// gaps and gives the verdict. Depends on sdeq_pkg, the block and its checker module.
module searchable_double_ended_queue_top_tb;

    // Codes outside the defined operations; the block must ignore them.
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int RANDOM_WORDS = 160;
    localparam int PHASE_WORDS  = 30;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    sdeq_pkg::t_in_item  i_cmd;
    logic                busy;
    logic                o_strobe;
    sdeq_pkg::t_out_item o_result;
    int                  fail_count;
    int                  pending;
    logic signed [sdeq_pkg::KEY_W-1:0] key_pool [8];

    searchable_double_ended_queue_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    searchable_double_ended_queue_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("FAILURE");
        $finish;
    end

    // Called at a falling edge; waits for the block to be free, presents the word and
    // returns at the falling edge after it is taken, leaving start high so a following
    // word can go out back to back.
    task automatic issue_command(input logic [2:0] kind,
                                 input logic signed [sdeq_pkg::KEY_W-1:0] key,
                                 input bit allow_gaps);
        sdeq_pkg::t_in_item w;
        w.kind = kind;
        w.key  = key;
        if (allow_gaps && $urandom_range(99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        // busy only moves at a rising edge, so its value here holds at the next one.
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= w;
        @(negedge i_clk);
    endtask

    function automatic logic signed [sdeq_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(1)) return key_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    initial begin
        logic [2:0] kind;
        int         push_pct;
        int         pop_pct;
        int         roll;
        int         taken;
        int         phase;
        bit         gaps;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty cases first, then extremes of the key, duplicates, hits and misses.
        issue_command(sdeq_pkg::KIND_POP_FRONT, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_POP_BACK, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_LIST, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_SEARCH, 32'sh8000_0000, 1'b1);
        issue_command(sdeq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000, 1'b1);
        issue_command(sdeq_pkg::KIND_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1);
        issue_command(sdeq_pkg::KIND_PUSH_FRONT, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_PUSH_BACK, -32'sd1, 1'b1);
        issue_command(sdeq_pkg::KIND_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1);
        issue_command(sdeq_pkg::KIND_LIST, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_SEARCH, 32'sh7FFF_FFFF, 1'b1);
        issue_command(sdeq_pkg::KIND_SEARCH, 32'sd1, 1'b1);
        issue_command(KIND_SPARE_LO, 32'sh7FFF_FFFF, 1'b1);
        issue_command(KIND_SPARE_HI, -32'sd1, 1'b1);
        issue_command(sdeq_pkg::KIND_POP_BACK, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_POP_FRONT, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_LIST, '0, 1'b1);
        issue_command(sdeq_pkg::KIND_SEARCH, -32'sd1, 1'b1);

        // Phases lean toward filling or draining so that the full and empty
        // edges are crossed many times; the middle stretch has no gaps.
        taken = 0;
        while (taken < RANDOM_WORDS) begin
            phase = (taken / PHASE_WORDS) % 3;
            case (phase)
                0: begin push_pct = 80; pop_pct = 5; end
                1: begin push_pct = 40; pop_pct = 35; end
                default: begin push_pct = 5; pop_pct = 80; end
            endcase
            roll = $urandom_range(99);
            if (roll < push_pct) begin
                kind = $urandom_range(1) ? sdeq_pkg::KIND_PUSH_BACK
                                         : sdeq_pkg::KIND_PUSH_FRONT;
            end else if (roll < push_pct + pop_pct) begin
                kind = $urandom_range(1) ? sdeq_pkg::KIND_POP_BACK
                                         : sdeq_pkg::KIND_POP_FRONT;
            end else if (roll < 97) begin
                kind = $urandom_range(1) ? sdeq_pkg::KIND_SEARCH : sdeq_pkg::KIND_LIST;
            end else begin
                kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
            end
            gaps = (taken < 60 || taken >= 120);
            issue_command(kind, pick_key(), gaps);
            if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI) taken++;
        end
        start <= 1'b0;

        while (pending != 0 || busy) @(negedge i_clk);
        repeat (sdeq_pkg::DEPTH + 6) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
